/* hw/rtl/prqws_pkg.sv */
// ----------------------------------------------------------------------------
// Per-CPU run queue package
// Shared defaults, field widths and codes of the per-CPU run queue block.
// ----------------------------------------------------------------------------
package prqws_pkg;

  localparam int NumCpusDef    = 4;
  localparam int QueueDepthDef = 16;
  localparam int TaskIdBitsDef = 8;

  localparam int ActiveW  = 3;
  localparam int CpuFieldW = 2;

  localparam logic [ActiveW-1:0] ActiveReset = 3'd4;

  localparam logic ModeAdd   = 1'b0;
  localparam logic ModeSched = 1'b1;

endpackage

/* hw/rtl/percpu_runqueue_work_stealing.sv */
// ----------------------------------------------------------------------------
// Per-CPU run queues with work stealing
// One FIFO of task ids per CPU in a shared queue memory; add and schedule
// items, with stealing from the most loaded active queue.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Its result appears on
// the result ports with done_o high for a single cycle, and the receiver cannot
// stall it. Unless no CPU is active, an item first walks the per-queue entry
// counts, one active queue per cycle, and then decides in ST_DEC; an add, a keep
// of the current task or a fall back to idle ends there, while a pop of the own
// queue or a steal goes on to ST_RESP, which takes the registered read of the
// queue memory. busy is low in the cycle of the strobe, so the next item can be
// taken there.
module percpu_runqueue_work_stealing #(
  parameter int CPU_COUNT    = prqws_pkg::NumCpusDef,
  parameter int QUEUE_DEPTH  = prqws_pkg::QueueDepthDef,
  parameter int TASK_ID_BITS = prqws_pkg::TaskIdBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              mode_i,
  input  logic [prqws_pkg::CpuFieldW-1:0]   cpu_i,
  input  logic [TASK_ID_BITS-1:0]           task_id_i,
  input  logic                              current_running_i,
  input  logic                              current_is_idle_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [prqws_pkg::ActiveW-1:0]     cfg_data_i,
  output logic                              done_o,
  output logic [TASK_ID_BITS-1:0]           next_task_o,
  output logic                              next_is_idle_o,
  output logic                              do_switch_o,
  output logic                              stolen_o,
  output logic [prqws_pkg::CpuFieldW-1:0]   source_cpu_o,
  output logic                              overflow_o
);

  localparam int CpuW     = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
  localparam int PtrW     = $clog2(QUEUE_DEPTH);
  localparam int CntW     = $clog2(QUEUE_DEPTH + 1);
  localparam int AddrW    = CpuW + PtrW;
  localparam int MemDepth = 1 << AddrW;
  localparam int AW       = prqws_pkg::ActiveW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DEC,
    ST_RESP
  } state_e;

  state_e                  state_q;
  logic [AW-1:0]           active_q;
  logic [AW-1:0]           n_q;
  logic [AW-1:0]           n_c;
  logic [CpuW-1:0]         idx_q;
  logic                    mode_q;
  logic [prqws_pkg::CpuFieldW-1:0] cpu_q;
  logic [TASK_ID_BITS-1:0] tid_q;
  logic                    run_q;
  logic                    cidle_q;
  logic [CntW-1:0]         own_cnt_q;
  logic [CpuW-1:0]         best_q;
  logic [CntW-1:0]         best_cnt_q;
  logic                    found_q;
  logic [CpuW-1:0]         tgt_q;
  logic                    pop_own_q;

  logic [PtrW-1:0]         head_q [CPU_COUNT];
  logic [PtrW-1:0]         tail_q [CPU_COUNT];
  logic [CntW-1:0]         cnt_q  [CPU_COUNT];

  logic [TASK_ID_BITS-1:0] mem [MemDepth];
  logic [TASK_ID_BITS-1:0] rd_data_q;

  logic                    own_ok;
  logic                    own_has;
  logic                    keep_cur;
  logic                    can_push;
  logic [CpuW-1:0]         tgt_c;
  logic [CpuW-1:0]         ptr_idx;
  logic [PtrW-1:0]         hd;
  logic [PtrW-1:0]         tl;
  logic [CntW-1:0]         scan_cnt;
  logic                    upd_we;
  logic [PtrW-1:0]         head_nx;
  logic [PtrW-1:0]         tail_nx;
  logic [CntW-1:0]         cnt_nx;
  logic                    mem_we;
  logic [AddrW-1:0]        mem_waddr;
  logic [AddrW-1:0]        rd_addr;

  logic                    done_q;
  logic [TASK_ID_BITS-1:0] next_task_q;
  logic                    next_is_idle_q;
  logic                    do_switch_q;
  logic                    stolen_q;
  logic [prqws_pkg::CpuFieldW-1:0] source_cpu_q;
  logic                    overflow_q;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PtrW'(1);
    end
    return r;
  endfunction

  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  assign done_o         = done_q;
  assign next_task_o    = next_task_q;
  assign next_is_idle_o = next_is_idle_q;
  assign do_switch_o    = do_switch_q;
  assign stolen_o       = stolen_q;
  assign source_cpu_o   = source_cpu_q;
  assign overflow_o     = overflow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= prqws_pkg::ActiveReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      active_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (32'(active_q) < CPU_COUNT) begin
      n_c = active_q;
    end else begin
      n_c = AW'(CPU_COUNT);
    end
  end

  assign own_ok   = AW'(cpu_q) < n_q;
  assign own_has  = own_ok && (own_cnt_q != '0);
  assign keep_cur = run_q && !cidle_q;
  assign can_push = own_ok && (own_cnt_q < CntW'(QUEUE_DEPTH));
  assign scan_cnt = cnt_q[idx_q];

  always_comb begin
    if ((mode_q == prqws_pkg::ModeAdd) || own_has) begin
      tgt_c = CpuW'(cpu_q);
    end else begin
      tgt_c = best_q;
    end
    ptr_idx = (state_q == ST_RESP) ? tgt_q : tgt_c;
    hd      = head_q[ptr_idx];
    tl      = tail_q[ptr_idx];
    rd_addr = {tgt_c, hd};

    upd_we    = 1'b0;
    head_nx   = hd;
    tail_nx   = tl;
    cnt_nx    = own_cnt_q;
    mem_we    = 1'b0;
    mem_waddr = {ptr_idx, tl};

    if ((state_q == ST_DEC) && (mode_q == prqws_pkg::ModeAdd) && can_push) begin
      upd_we  = 1'b1;
      mem_we  = 1'b1;
      tail_nx = ptr_inc(tl);
      cnt_nx  = own_cnt_q + CntW'(1);
    end else if (state_q == ST_RESP) begin
      upd_we  = 1'b1;
      head_nx = ptr_inc(hd);
      if (pop_own_q) begin
        if (keep_cur) begin
          mem_we  = 1'b1;
          tail_nx = ptr_inc(tl);
        end else begin
          cnt_nx = own_cnt_q - CntW'(1);
        end
      end else begin
        cnt_nx = best_cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= tid_q;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CPU_COUNT; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else if (upd_we) begin
      head_q[ptr_idx] <= head_nx;
      tail_q[ptr_idx] <= tail_nx;
      cnt_q[ptr_idx]  <= cnt_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      n_q            <= '0;
      idx_q          <= '0;
      mode_q         <= prqws_pkg::ModeAdd;
      cpu_q          <= '0;
      tid_q          <= '0;
      run_q          <= 1'b0;
      cidle_q        <= 1'b0;
      own_cnt_q      <= '0;
      best_q         <= '0;
      best_cnt_q     <= '0;
      found_q        <= 1'b0;
      tgt_q          <= '0;
      pop_own_q      <= 1'b0;
      done_q         <= 1'b0;
      next_task_q    <= '0;
      next_is_idle_q <= 1'b0;
      do_switch_q    <= 1'b0;
      stolen_q       <= 1'b0;
      source_cpu_q   <= '0;
      overflow_q     <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            mode_q     <= mode_i;
            cpu_q      <= cpu_i;
            tid_q      <= task_id_i;
            run_q      <= current_running_i;
            cidle_q    <= current_is_idle_i;
            n_q        <= n_c;
            idx_q      <= '0;
            own_cnt_q  <= '0;
            best_q     <= '0;
            best_cnt_q <= '0;
            found_q    <= 1'b0;
            state_q    <= (n_c == '0) ? ST_DEC : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (5'(idx_q) == 5'(cpu_q)) begin
            own_cnt_q <= scan_cnt;
          end
          if (scan_cnt > best_cnt_q) begin
            best_cnt_q <= scan_cnt;
            best_q     <= idx_q;
            found_q    <= 1'b1;
          end
          if (32'(idx_q) == 32'(n_q) - 1) begin
            state_q <= ST_DEC;
          end else begin
            idx_q <= idx_q + CpuW'(1);
          end
        end
        ST_DEC: begin
          tgt_q          <= tgt_c;
          next_task_q    <= '0;
          next_is_idle_q <= 1'b0;
          do_switch_q    <= 1'b0;
          stolen_q       <= 1'b0;
          source_cpu_q   <= '0;
          overflow_q     <= 1'b0;
          if (mode_q == prqws_pkg::ModeAdd) begin
            overflow_q <= !can_push;
            done_q     <= 1'b1;
            state_q    <= ST_IDLE;
          end else if (own_has) begin
            pop_own_q <= 1'b1;
            state_q   <= ST_RESP;
          end else if (keep_cur) begin
            next_task_q <= tid_q;
            done_q      <= 1'b1;
            state_q     <= ST_IDLE;
          end else if (found_q) begin
            pop_own_q <= 1'b0;
            state_q   <= ST_RESP;
          end else begin
            next_is_idle_q <= 1'b1;
            do_switch_q    <= !cidle_q;
            done_q         <= 1'b1;
            state_q        <= ST_IDLE;
          end
        end
        ST_RESP: begin
          next_task_q    <= rd_data_q;
          next_is_idle_q <= 1'b0;
          do_switch_q    <= cidle_q || (rd_data_q != tid_q);
          if (!pop_own_q && (5'(best_q) != 5'(cpu_q))) begin
            stolen_q     <= 1'b1;
            source_cpu_q <= prqws_pkg::CpuFieldW'(best_q);
          end else begin
            stolen_q     <= 1'b0;
            source_cpu_q <= '0;
          end
          overflow_q <= 1'b0;
          done_q     <= 1'b1;
          state_q    <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
